@@ src/battery_monitor_cutoff_defines.svh @@
// Assertion macros used by the checker file of battery_monitor_cutoff.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef BATTERY_MONITOR_CUTOFF_DEFINES_SVH
`define BATTERY_MONITOR_CUTOFF_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bmc_pkg.sv @@
// Shared types, register codes and curve tables of the battery monitor.
// No dependencies; imported by every module of the block.
package bmc_pkg;

    localparam int AdcBitsDefault    = 12;
    localparam int QueueDepthDefault = 2;

    // configuration port
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] RegVoltFullScale = 3'd0;
    localparam logic [CfgIdxW-1:0] RegAdcRef        = 3'd1;
    localparam logic [CfgIdxW-1:0] RegCurrentOffset = 3'd2;
    localparam logic [CfgIdxW-1:0] RegCurrentGain   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegOvercurrent   = 3'd4;
    localparam logic [CfgIdxW-1:0] RegCutoff        = 3'd5;
    localparam logic [CfgIdxW-1:0] RegQuietCurrent  = 3'd6;

    typedef struct packed {
        logic [15:0] volt_full_scale_mv;
        logic [11:0] adc_ref_mv;
        logic [11:0] current_offset_mv;
        logic [15:0] current_gain_q8;
        logic [15:0] overcurrent_ma;
        logic [15:0] cutoff_mv;
        logic [15:0] quiet_current_ma;
    } cfg_t;

    localparam cfg_t CfgReset = '{
        volt_full_scale_mv: 16'd9900,
        adc_ref_mv:         12'd3300,
        current_offset_mv:  12'd2332,
        current_gain_q8:    16'd2560,
        overcurrent_ma:     16'd15000,
        cutoff_mv:          16'd6600,
        quiet_current_ma:   16'd600
    };

    // state reset and filter weights (new sample 13107/65536, history the rest)
    localparam logic [15:0] HeldReset = 16'd8400;
    localparam logic [15:0] EmaTake   = 16'd13107;
    localparam logic [15:0] EmaKeep   = 16'd52429;

    // shared multiplier
    localparam int MulAW = 20;
    localparam int MulBW = 16;
    localparam int MulPW = MulAW + MulBW;
    localparam int FiltW = 20;

    // charge curve, 2S LiPo
    localparam int CurvePoints = 11;
    localparam int SegW        = $clog2(CurvePoints);
    localparam int DiffW       = 9;
    localparam int RecipW      = 13;
    localparam int PctW        = 7;
    localparam int PctShift    = 16;

    localparam logic [15:0] CurveMv [CurvePoints] = '{
        16'd6600, 16'd6800, 16'd6950, 16'd7100, 16'd7240, 16'd7400,
        16'd7550, 16'd7720, 16'd7900, 16'd8100, 16'd8400
    };
    localparam logic [PctW-1:0] CurvePct [CurvePoints] = '{
        7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50,
        7'd60, 7'd70, 7'd80, 7'd90, 7'd100
    };
    // round(10 * 65536 / segment width); last point has no segment
    localparam logic [RecipW-1:0] CurveRecip [CurvePoints] = '{
        13'd3277, 13'd4369, 13'd4369, 13'd4681, 13'd4096, 13'd4369,
        13'd3855, 13'd3641, 13'd3277, 13'd2185, 13'd0
    };

    // result beat, last field in the lowest bits
    typedef struct packed {
        logic            relay_open;
        logic [PctW-1:0] charge_percent;
        logic [15:0]     current_ma;
        logic [15:0]     voltage_mv;
    } out_item_t;

    localparam int OutW = $bits(out_item_t);

endpackage

@@ src/bmc_front.sv @@
// Front end: stream slave side and configuration register file.
// Depends on bmc_pkg; feeds bmc_queue and hands the register set to bmc_back.
module bmc_front
    import bmc_pkg::*;
#(
    parameter int ADC_BITS = AdcBitsDefault
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // s_tdata: voltage_code, current_code (ADC_BITS each), zero pad
    input  logic [((2*ADC_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [CfgIdxW-1:0]                   cfg_index,
    input  logic [CfgDataW-1:0]                  cfg_data,
    input  logic                                 queue_ready,
    output logic                                 push,
    output logic [2*ADC_BITS-1:0]                push_data,
    output cfg_t                                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign s_tready  = queue_ready;
    assign push      = s_tvalid && queue_ready;
    assign push_data = s_tdata[2*ADC_BITS-1:0];
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                RegVoltFullScale: cfg_next.volt_full_scale_mv = cfg_data;
                RegAdcRef:        cfg_next.adc_ref_mv         = cfg_data[11:0];
                RegCurrentOffset: cfg_next.current_offset_mv  = cfg_data[11:0];
                RegCurrentGain:   cfg_next.current_gain_q8    = cfg_data;
                RegOvercurrent:   cfg_next.overcurrent_ma     = cfg_data;
                RegCutoff:        cfg_next.cutoff_mv          = cfg_data;
                RegQuietCurrent:  cfg_next.quiet_current_ma   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CfgReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ src/bmc_queue.sv @@
// Short FIFO of accepted sample pairs between front and back end.
// Depends on bmc_pkg for default sizes.
module bmc_queue
    import bmc_pkg::*;
#(
    parameter int W     = 2 * AdcBitsDefault,
    parameter int DEPTH = QueueDepthDefault
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         push_ready,
    input  logic         pop,
    output logic         pop_valid,
    output logic [W-1:0] pop_data
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [W-1:0]    mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            push_ok;
    logic            pop_ok;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push_ok    = push && push_ready;
    assign pop_ok     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/bmc_back.sv @@
// Back end: sequencer around one shared multiplier and an iterative divider
// by the full ADC code; holds the monitor state and the output register.
// Depends on bmc_pkg; pops sample pairs from bmc_queue.
module bmc_back
    import bmc_pkg::*;
#(
    parameter int ADC_BITS = AdcBitsDefault
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  in_valid,
    input  logic [2*ADC_BITS-1:0] in_data,
    output logic                  in_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OutW-1:0]       m_tdata
);

    localparam int PW = ADC_BITS + 16;
    localparam int AW = PW - ADC_BITS;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'h0001,
        ST_MUL_V = 14'h0002,
        ST_DIV_V = 14'h0004,
        ST_MUL_I = 14'h0008,
        ST_DIV_I = 14'h0010,
        ST_DROP  = 14'h0020,
        ST_MUL_G = 14'h0040,
        ST_MUL_F = 14'h0080,
        ST_MUL_N = 14'h0100,
        ST_MIX   = 14'h0200,
        ST_HOLD  = 14'h0400,
        ST_SEG   = 14'h0800,
        ST_MUL_P = 14'h1000,
        ST_FIN   = 14'h2000
    } state_t;

    state_t              state_reg, state_next;
    logic [15:0]         held_reg, held_next;
    logic [FiltW-1:0]    filt_reg, filt_next;
    logic                latch_reg, latch_next;
    logic                out_valid_reg, out_valid_next;

    logic [ADC_BITS-1:0] vcode_reg, vcode_next;
    logic [ADC_BITS-1:0] icode_reg, icode_next;
    logic [PW-1:0]       r_reg, r_next;
    logic [15:0]         q_reg, q_next;
    logic [15:0]         vraw_reg, vraw_next;
    logic [15:0]         pin_reg, pin_next;
    logic [11:0]         drop_reg, drop_next;
    logic [MulPW-1:0]    prod_reg, prod_next;
    logic [MulPW-1:0]    acc_reg, acc_next;
    logic [15:0]         iraw_reg, iraw_next;
    logic [SegW-1:0]     seg_reg, seg_next;
    logic [DiffW-1:0]    diff_reg, diff_next;
    logic                top_reg, top_next;
    logic                bot_reg, bot_next;
    out_item_t           out_data_reg, out_data_next;

    logic [MulAW-1:0]    mul_a;
    logic [MulBW-1:0]    mul_b;
    logic [MulPW-1:0]    mul_p;
    logic [AW-1:0]       div_a;
    logic [ADC_BITS-1:0] div_b;
    logic [AW:0]         div_sum;
    logic                div_done;
    logic [15:0]         div_quot;
    logic [MulPW-1:0]    mix;
    logic [15:0]         held_new;
    logic [SegW-1:0]     seg_c;
    logic [PctW-1:0]     pct_c;

    assign mul_p = MulPW'(mul_a) * MulPW'(mul_b);

    // x / (2^N - 1): fold the high part onto the low part until it fits
    assign div_a    = r_reg[PW-1:ADC_BITS];
    assign div_b    = r_reg[ADC_BITS-1:0];
    assign div_sum  = (AW+1)'(div_a) + (AW+1)'(div_b);
    assign div_done = (div_a == '0);
    assign div_quot = q_reg + 16'(div_b == {ADC_BITS{1'b1}});

    assign mix      = acc_reg + prod_reg;
    assign held_new = (filt_reg < {cfg.quiet_current_ma, 4'b0000}) ? vraw_reg : held_reg;

    always_comb
    begin
        seg_c = '0;
        for (int k = 0; k < CurvePoints - 1; k++)
        begin
            if (held_reg >= CurveMv[k])
            begin
                seg_c = SegW'(k);
            end
        end
    end

    always_comb
    begin
        if (top_reg)
        begin
            pct_c = CurvePct[CurvePoints-1];
        end
        else if (bot_reg)
        begin
            pct_c = CurvePct[0];
        end
        else
        begin
            pct_c = CurvePct[seg_reg] + prod_reg[PctShift +: PctW];
        end
    end

    assign in_pop   = (state_reg == ST_IDLE) && in_valid;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        filt_next      = filt_reg;
        latch_next     = latch_reg;
        out_valid_next = out_valid_reg && !m_tready;
        vcode_next     = vcode_reg;
        icode_next     = icode_reg;
        r_next         = r_reg;
        q_next         = q_reg;
        vraw_next      = vraw_reg;
        pin_next       = pin_reg;
        drop_next      = drop_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        iraw_next      = iraw_reg;
        seg_next       = seg_reg;
        diff_next      = diff_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        out_data_next  = out_data_reg;
        mul_a          = '0;
        mul_b          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    vcode_next = in_data[ADC_BITS-1:0];
                    icode_next = in_data[2*ADC_BITS-1:ADC_BITS];
                    state_next = ST_MUL_V;
                end
            end
            ST_MUL_V:
            begin
                mul_a      = MulAW'(vcode_reg);
                mul_b      = cfg.volt_full_scale_mv;
                r_next     = mul_p[PW-1:0];
                q_next     = '0;
                state_next = ST_DIV_V;
            end
            ST_DIV_V:
            begin
                if (div_done)
                begin
                    vraw_next  = div_quot;
                    state_next = ST_MUL_I;
                end
                else
                begin
                    q_next = q_reg + div_a;
                    r_next = PW'(div_sum);
                end
            end
            ST_MUL_I:
            begin
                mul_a      = MulAW'(icode_reg);
                mul_b      = MulBW'(cfg.adc_ref_mv);
                r_next     = mul_p[PW-1:0];
                q_next     = '0;
                state_next = ST_DIV_I;
            end
            ST_DIV_I:
            begin
                if (div_done)
                begin
                    pin_next   = div_quot;
                    state_next = ST_DROP;
                end
                else
                begin
                    q_next = q_reg + div_a;
                    r_next = PW'(div_sum);
                end
            end
            ST_DROP:
            begin
                // clamp: pin above offset means no discharge current
                if (16'(cfg.current_offset_mv) > pin_reg)
                begin
                    drop_next = 12'(16'(cfg.current_offset_mv) - pin_reg);
                end
                else
                begin
                    drop_next = '0;
                end
                state_next = ST_MUL_G;
            end
            ST_MUL_G:
            begin
                mul_a      = MulAW'(drop_reg);
                mul_b      = cfg.current_gain_q8;
                prod_next  = mul_p;
                state_next = ST_MUL_F;
            end
            ST_MUL_F:
            begin
                iraw_next  = (|prod_reg[MulPW-1:24]) ? 16'hFFFF : prod_reg[23:8];
                mul_a      = filt_reg;
                mul_b      = EmaKeep;
                acc_next   = mul_p;
                state_next = ST_MUL_N;
            end
            ST_MUL_N:
            begin
                mul_a      = {iraw_reg, 4'b0000};
                mul_b      = EmaTake;
                prod_next  = mul_p;
                state_next = ST_MIX;
            end
            ST_MIX:
            begin
                filt_next  = mix[MulPW-1:16];
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                held_next = held_new;
                if ((filt_reg > {cfg.overcurrent_ma, 4'b0000}) || (held_new < cfg.cutoff_mv))
                begin
                    latch_next = 1'b1;
                end
                state_next = ST_SEG;
            end
            ST_SEG:
            begin
                seg_next   = seg_c;
                diff_next  = DiffW'(held_reg - CurveMv[seg_c]);
                top_next   = (held_reg >= CurveMv[CurvePoints-1]);
                bot_next   = (held_reg <= CurveMv[0]);
                state_next = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                mul_a      = MulAW'(diff_reg);
                mul_b      = MulBW'(CurveRecip[seg_reg]);
                prod_next  = mul_p;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // hold here while the previous result still waits
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.voltage_mv     = held_reg;
                    out_data_next.current_ma     = filt_reg[FiltW-1:4];
                    out_data_next.charge_percent = pct_c;
                    out_data_next.relay_open     = latch_reg;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= HeldReset;
            filt_reg      <= '0;
            latch_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            filt_reg      <= filt_next;
            latch_reg     <= latch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vcode_reg    <= vcode_next;
        icode_reg    <= icode_next;
        r_reg        <= r_next;
        q_reg        <= q_next;
        vraw_reg     <= vraw_next;
        pin_reg      <= pin_next;
        drop_reg     <= drop_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        iraw_reg     <= iraw_next;
        seg_reg      <= seg_next;
        diff_reg     <= diff_next;
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        out_data_reg <= out_data_next;
    end

endmodule

@@ src/battery_monitor_cutoff.sv @@
// The back end takes one item at a time, through a sequencer around one shared
// 20x16 multiplier and two divide-by-full-code passes; it holds a result on
// m_tdata while m_tready is low. A two-entry queue lets the input side take beats
// while the back end works.
// Reset (rst_n, asynchronous): registers to defaults, held voltage 8400 mV,
// filtered current 0, relay closed; no clearing pass.
module battery_monitor_cutoff
    import bmc_pkg::*;
#(
    parameter int ADC_BITS    = AdcBitsDefault,
    parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: voltage_code, current_code (ADC_BITS each), zero pad
    input  logic [((2*ADC_BITS+7)/8)*8-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: voltage_mv[15:0], current_ma[31:16], charge_percent[38:32],
    //          relay_open[39]
    output logic [OutW-1:0]                 m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [CfgIdxW-1:0]              cfg_index,
    input  logic [CfgDataW-1:0]             cfg_data
);

    cfg_t                  cfg;
    logic                  push;
    logic [2*ADC_BITS-1:0] push_data;
    logic                  queue_ready;
    logic                  pop;
    logic                  pop_valid;
    logic [2*ADC_BITS-1:0] pop_data;

    bmc_front #(
        .ADC_BITS (ADC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_ready (queue_ready),
        .push        (push),
        .push_data   (push_data),
        .cfg         (cfg)
    );

    bmc_queue #(
        .W     (2 * ADC_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (queue_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    bmc_back #(
        .ADC_BITS (ADC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (pop_valid),
        .in_data  (pop_data),
        .in_pop   (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ src/bmc_checker.sv @@
// Port-level checker for battery_monitor_cutoff, attached by bind.
// Depends on bmc_pkg and battery_monitor_cutoff_defines.svh.
`include "battery_monitor_cutoff_defines.svh"

module bmc_checker
    import bmc_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            m_tvalid,
    input logic            m_tready,
    input logic [OutW-1:0] m_tdata
);

    out_item_t beat;
    logic      seen_open_reg;
    logic      seen_open_next;

    assign beat           = m_tdata;
    assign seen_open_next = seen_open_reg || (m_tvalid && m_tready && beat.relay_open);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_open_reg <= 1'b0;
        end
        else
        begin
            seen_open_reg <= seen_open_next;
        end
    end

    `BMC_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `BMC_ASSERT_IMP(a_relay_sticky, m_tvalid && seen_open_reg, beat.relay_open, "relay closed again after cutoff")
    `BMC_ASSERT_IMP(a_pct_empty, m_tvalid && (beat.voltage_mv <= CurveMv[0]), beat.charge_percent == CurvePct[0], "charge not empty at bottom of curve")
    `BMC_ASSERT_IMP(a_pct_full, m_tvalid && (beat.voltage_mv >= CurveMv[CurvePoints-1]), beat.charge_percent == CurvePct[CurvePoints-1], "charge not full at top of curve")

endmodule

bind battery_monitor_cutoff bmc_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ sim/tb.sv @@
// Self-checking bench for battery_monitor_cutoff: a directed table split around
// randomized phases with mixed pacing, every reading checked against a local model or a table entry.
// Depends on bmc_pkg and the battery_monitor_cutoff RTL.
module tb;
    import bmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 8;
    localparam int PHASE_SAMPLES  = 86;
    localparam int TAIL_CYCLES    = 40;

    localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

    localparam longint unsigned EmaNew = 13107;
    localparam longint unsigned EmaOld = 52429;

    // 2S LiPo discharge curve and per-segment reciprocals
    localparam logic [15:0] KneeMv [11] = '{
        16'd6600, 16'd6800, 16'd6950, 16'd7100, 16'd7240, 16'd7400,
        16'd7550, 16'd7720, 16'd7900, 16'd8100, 16'd8400
    };
    localparam logic [6:0] KneePct [11] = '{
        7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
    };
    localparam logic [12:0] KneeRecip [10] = '{
        13'd3277, 13'd4369, 13'd4369, 13'd4681, 13'd4096,
        13'd4369, 13'd3855, 13'd3641, 13'd3277, 13'd2185
    };

    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_e;

    // sample rows: a = voltage code, b = current code; register rows: a = index, b = data
    typedef struct packed {
        row_kind_e  kind;
        logic [15:0] a;
        logic [15:0] b;
        logic        known;
        out_item_t   want;
    } row_t;

    localparam out_item_t NoCheck = '0;

    localparam int SAFE_ROWS   = 26;
    localparam int SCRIPT_ROWS = 33;

    localparam row_t Script [SCRIPT_ROWS] = '{
        // defaults after reset: full-scale voltage, no current
        '{ROW_SAMPLE, 16'd4095, 16'd4095, 1'b1, '{1'b0, 7'd100, 16'd0, 16'd9900}},
        '{ROW_REG,    16'(RegCutoff),       16'd0,     1'b0, NoCheck},
        '{ROW_REG,    16'(RegOvercurrent),  16'hFFFF,  1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd0,    16'd4095, 1'b1, '{1'b0, 7'd0, 16'd0, 16'd0}},
        '{ROW_SAMPLE, 16'd4095, 16'd0,    1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd2730, 16'd2048, 1'b0, NoCheck},
        '{ROW_SAMPLE, 16'hAAA,  16'h555,  1'b0, NoCheck},
        '{ROW_SAMPLE, 16'h555,  16'hAAA,  1'b0, NoCheck},
        // raw current saturation
        '{ROW_REG,    16'(RegCurrentGain),   16'hFFFF, 1'b0, NoCheck},
        '{ROW_REG,    16'(RegCurrentOffset), 16'h0FFF, 1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd4095, 16'd0,    1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd4095, 16'd0,    1'b0, NoCheck},
        // over-wide data is masked, unknown index is dropped
        '{ROW_REG,    16'(RegAdcRef),        16'hFFFF, 1'b0, NoCheck},
        '{ROW_REG,    16'(RegUnused),        16'hFFFF, 1'b0, NoCheck},
        '{ROW_REG,    16'(RegQuietCurrent),  16'hFFFF, 1'b0, NoCheck},
        '{ROW_REG,    16'(RegCurrentGain),   16'd0,    1'b0, NoCheck},
        // held voltage = 2 * code: walk the charge curve
        '{ROW_REG,    16'(RegVoltFullScale), 16'd8190, 1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd3300, 16'd4095, 1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd3400, 16'd4095, 1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd3475, 16'd0,    1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd3620, 16'd2048, 1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd3860, 16'd4095, 1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd4050, 16'd4095, 1'b0, NoCheck},
        // zero registers
        '{ROW_REG,    16'(RegVoltFullScale), 16'd0,    1'b0, NoCheck},
        '{ROW_REG,    16'(RegCurrentOffset), 16'd0,    1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd4095, 16'd4095, 1'b0, NoCheck},
        // latch: trip on under-voltage, then stay open once conditions clear
        '{ROW_REG,    16'(RegQuietCurrent),  16'hFFFF, 1'b0, NoCheck},
        '{ROW_REG,    16'(RegVoltFullScale), 16'd9900, 1'b0, NoCheck},
        '{ROW_REG,    16'(RegCutoff),        16'd6600, 1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd0,    16'd4095, 1'b0, NoCheck},
        '{ROW_REG,    16'(RegCutoff),        16'd0,    1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd4095, 16'd4095, 1'b0, NoCheck},
        '{ROW_SAMPLE, 16'd4095, 16'd0,    1'b0, NoCheck}
    };

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [23:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutW-1:0]     m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    // monitor model state
    cfg_t        live_cfg;
    logic [15:0] held_mv;
    logic [19:0] ema_q4;
    logic        relay_latched;

    out_item_t pending_readings [$];
    out_item_t reading;
    out_item_t wanted;

    int send_idle;
    int recv_stall;
    int err_count;
    int samples_sent;
    int readings_seen;
    int reg_writes;
    int idle_cycles;

    battery_monitor_cutoff uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [6:0] charge_at(logic [15:0] mv);
        logic [31:0] part;
        if (mv >= KneeMv[10])
            return KneePct[10];
        if (mv <= KneeMv[0])
            return KneePct[0];
        for (int k = 0; k < 10; k++)
        begin
            if (mv < KneeMv[k + 1])
            begin
                part = (32'(mv - KneeMv[k]) * KneeRecip[k]) >> 16;
                return KneePct[k] + part[6:0];
            end
        end
        return KneePct[0];
    endfunction

    function automatic void reset_model();
        live_cfg = '{
            volt_full_scale_mv: 16'd9900,
            adc_ref_mv:         12'd3300,
            current_offset_mv:  12'd2332,
            current_gain_q8:    16'd2560,
            overcurrent_ma:     16'd15000,
            cutoff_mv:          16'd6600,
            quiet_current_ma:   16'd600
        };
        held_mv       = 16'd8400;
        ema_q4        = 20'd0;
        relay_latched = 1'b0;
    endfunction

    function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
        case (idx)
            RegVoltFullScale: live_cfg.volt_full_scale_mv = data;
            RegAdcRef:        live_cfg.adc_ref_mv = data[11:0];
            RegCurrentOffset: live_cfg.current_offset_mv = data[11:0];
            RegCurrentGain:   live_cfg.current_gain_q8 = data;
            RegOvercurrent:   live_cfg.overcurrent_ma = data;
            RegCutoff:        live_cfg.cutoff_mv = data;
            RegQuietCurrent:  live_cfg.quiet_current_ma = data;
            default:          ;
        endcase
    endfunction

    // advance the monitor state by one ADC pair and return the reading it shows
    function automatic out_item_t predict_reading(logic [11:0] volt, logic [11:0] load);
        logic [27:0]     vprod;
        logic [23:0]     pprod;
        logic [11:0]     pin;
        logic [11:0]     drop;
        logic [27:0]     iprod;
        logic [19:0]     iscaled;
        logic [15:0]     iraw;
        longint unsigned mix;
        out_item_t       r;
        vprod   = volt * live_cfg.volt_full_scale_mv;
        pprod   = load * live_cfg.adc_ref_mv;
        pin     = 12'(pprod / 24'd4095);
        drop    = (live_cfg.current_offset_mv > pin) ? live_cfg.current_offset_mv - pin : 12'd0;
        iprod   = drop * live_cfg.current_gain_q8;
        iscaled = iprod[27:8];
        iraw    = (iscaled > 20'd65535) ? 16'hFFFF : iscaled[15:0];
        mix     = EmaNew * longint'({iraw, 4'b0000}) + EmaOld * longint'(ema_q4);
        ema_q4  = mix[35:16];
        if (ema_q4 < {live_cfg.quiet_current_ma, 4'b0000})
            held_mv = 16'(vprod / 28'd4095);
        if (ema_q4 > {live_cfg.overcurrent_ma, 4'b0000} || held_mv < live_cfg.cutoff_mv)
            relay_latched = 1'b1;
        r.voltage_mv     = held_mv;
        r.current_ma     = ema_q4[19:4];
        r.charge_percent = charge_at(held_mv);
        r.relay_open     = relay_latched;
        return r;
    endfunction

    function automatic logic [15:0] pick_reg();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] pick_code();
        case ($urandom_range(7))
            0:       return 12'd0;
            1:       return 12'hFFF;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    task automatic flag_mismatch(string what, int unsigned seen, int unsigned want);
        $display("tb: reading %0d %s: got %0d, want %0d", readings_seen, what, seen, want);
        err_count++;
    endtask

    // drop the sample stream and hold until every pending reading is back
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_sample(logic [11:0] volt, logic [11:0] load, logic known,
                               out_item_t typed);
        out_item_t model;
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {load, volt};
        do
            @(posedge clk);
        while (!s_tready);
        model = predict_reading(volt, load);
        pending_readings.push_back(known ? typed : model);
        samples_sent++;
    endtask

    task automatic walk_script(int first, int last);
        for (int r = first; r <= last; r++)
        begin
            if (Script[r].kind == ROW_REG)
                write_reg(Script[r].a[CfgIdxW-1:0], Script[r].b);
            else
                push_sample(Script[r].a[11:0], Script[r].b[11:0], Script[r].known,
                            Script[r].want);
        end
    endtask

    // trips stay disabled until the last phases so most of the run sees a closed relay
    task automatic program_phase(logic trips);
        write_reg(RegVoltFullScale, pick_reg());
        write_reg(RegAdcRef, pick_reg());
        write_reg(RegCurrentOffset, pick_reg());
        write_reg(RegCurrentGain, pick_reg());
        write_reg(RegQuietCurrent, pick_reg());
        write_reg(RegOvercurrent, trips ? 16'($urandom_range(20000)) : 16'hFFFF);
        write_reg(RegCutoff, trips ? 16'($urandom_range(7000)) : 16'd0);
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            reading = m_tdata;
            readings_seen++;
            if (pending_readings.size() == 0)
                flag_mismatch("arrived with nothing pending, voltage_mv", reading.voltage_mv, 0);
            else
            begin
                wanted = pending_readings.pop_front();
                if (reading.voltage_mv !== wanted.voltage_mv)
                    flag_mismatch("voltage_mv", reading.voltage_mv, wanted.voltage_mv);
                if (reading.current_ma !== wanted.current_ma)
                    flag_mismatch("current_ma", reading.current_ma, wanted.current_ma);
                if (reading.charge_percent !== wanted.charge_percent)
                    flag_mismatch("charge_percent", reading.charge_percent,
                                  wanted.charge_percent);
                if (reading.relay_open !== wanted.relay_open)
                    flag_mismatch("relay_open", reading.relay_open, wanted.relay_open);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: no beat moved in %0d cycles, %0d readings pending",
                     WATCHDOG_LIMIT, pending_readings.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [11:0] load;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle     = 0;
        recv_stall    = 0;
        err_count     = 0;
        samples_sent  = 0;
        readings_seen = 0;
        reg_writes    = 0;
        idle_cycles   = 0;
        load          = 12'd0;
        reset_model();
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;

        walk_script(0, SAFE_ROWS - 1);

        for (int p = 0; p < PHASES; p++)
        begin
            program_phase(p >= PHASES - 2);
            case (p % 4)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                end
                1:
                begin
                    send_idle  = 82;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 82;
                end
                default:
                begin
                    send_idle  = 21;
                    recv_stall = 21;
                end
            endcase
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                if (p == 1 && n == PHASE_SAMPLES / 2)
                    settle();
                // hold the load now and then so the filter can settle
                if ($urandom_range(3) != 0)
                    load = pick_code();
                push_sample(pick_code(), load, 1'b0, NoCheck);
            end
        end

        send_idle  = 0;
        recv_stall = 0;
        walk_script(SAFE_ROWS, SCRIPT_ROWS - 1);
        settle();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("tb: %0d ADC pairs, %0d register writes, %0d readings checked",
                 samples_sent, reg_writes, readings_seen);
        $display("tb: %0d random phases over all pacing modes, relay %s at the end",
                 PHASES, relay_latched ? "open" : "closed");
        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
